[src/pse_pkg.sv]
// Shared types, constants and elaboration helpers of the prime sieve enumerator.
package pse_pkg;

    // Width of the cursor. It can sit one above a limit of 65535.
    localparam int CAND_W  = 17;
    // Width of the limit register and of the prime result.
    localparam int VALUE_W = 16;
    // Width of a sieving prime. Only primes whose square fits under the limit are held.
    localparam int ROOT_W  = 8;
    // Number of cell hit flags combined in one register of the OR tree.
    localparam int GRP_SIZE = 8;
    // Largest limit that the 16-bit register can express.
    localparam int LIMIT_CEIL = 65535;

    localparam logic [VALUE_W-1:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [CAND_W-1:0]  CURSOR_START = 17'd2;

    // Register map, by register index (byte address divided by four).
    localparam logic REG_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_HIT,
        ST_DECIDE
    } pse_state_t;

    // Content of one cell, also what moves one cell down the row on an insert.
    typedef struct packed {
        logic              valid;
        logic [ROOT_W-1:0] p;
        logic [CAND_W-1:0] m;
    } pse_link_t;

    // Command from the sequencer to the row of cells.
    typedef struct packed {
        logic              clear;
        logic              test;
        logic              insert;
        logic [CAND_W-1:0] cand;
        pse_link_t         fresh;
    } pse_cmd_t;

    // Number of primes p with p*p <= n, at least one so that the row is never empty.
    function automatic int cells_for(input int n);
        logic [255:0] comp;
        int           r;
        int           cnt;
        comp = '0;
        r    = 0;
        cnt  = 0;
        for (int i = 1; i <= 255; i++) begin
            if (i * i <= n) begin
                r = i;
            end
        end
        for (int i = 2; i <= 255; i++) begin
            if (i <= r && !comp[i]) begin
                cnt++;
                for (int j = i * i; j <= 255; j += i) begin
                    comp[j] = 1'b1;
                end
            end
        end
        return (cnt < 1) ? 1 : cnt;
    endfunction

endpackage

[src/pse_cell.sv]
// One sieve cell: holds a sieving prime and its next multiple.
module pse_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  pse_pkg::pse_cmd_t  cmd,
    input  pse_pkg::pse_link_t link_in,
    output pse_pkg::pse_link_t link_out,
    output logic               hit
);

    logic                       valid_reg;
    logic [pse_pkg::ROOT_W-1:0] p_reg;
    logic [pse_pkg::CAND_W-1:0] m_reg;
    logic                       hit_reg;
    logic                       match;

    assign match = valid_reg && (m_reg == cmd.cand);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            valid_reg <= 1'b0;
        end else if (cmd.insert) begin
            valid_reg <= link_in.valid;
            p_reg     <= link_in.p;
            m_reg     <= link_in.m;
        end else if (cmd.test && match) begin
            // The candidate is this multiple, so move on to the next one.
            m_reg <= m_reg + pse_pkg::CAND_W'(p_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (cmd.test) begin
            hit_reg <= match;
        end
    end

    assign link_out.valid = valid_reg;
    assign link_out.p     = p_reg;
    assign link_out.m     = m_reg;
    assign hit            = hit_reg;

endmodule

[src/pse_chain.sv]
// Row of sieve cells with a registered OR tree over their hit flags.
module pse_chain #(
    parameter int NCELLS = 54
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pse_pkg::pse_cmd_t cmd,
    output logic              composite
);

    localparam int NGRP = (NCELLS + pse_pkg::GRP_SIZE - 1) / pse_pkg::GRP_SIZE;

    // One link more than cells: the last one is what an insert would push out of the row.
    pse_pkg::pse_link_t link [NCELLS+1];
    logic [NCELLS-1:0]  hit;
    logic [NGRP-1:0]    grp_reg;

    assign link[0] = cmd.fresh;

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        pse_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .hit      (hit[i])
        );
    end

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        localparam int LO = g * pse_pkg::GRP_SIZE;
        localparam int HI = (LO + pse_pkg::GRP_SIZE > NCELLS) ? NCELLS - 1
                                                               : LO + pse_pkg::GRP_SIZE - 1;
        always_ff @(posedge aclk) begin
            grp_reg[g] <= |hit[HI:LO];
        end
    end

    assign composite = |grp_reg;

    // The row holds every sieving prime up to the largest limit, so an insert never
    // pushes a live entry out of the last cell.
    a_row_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.insert && !cmd.clear) |-> !link[NCELLS].valid)
        else $error("sieving prime pushed out of the row");

endmodule

[src/prime_sieve_enumerator.sv]
// Top level of the prime sieve enumerator: sequencer, registers and result stage.
//
// Channel   Direction  Payload                             Request moves
// s_        in         s_tdata[0] restart                  one enumeration request
// m_        out        m_tdata prime, m_tuser[0] exhausted one result
// APB       in/out     limit at byte address 0             register write or read
//
// Each candidate number passes the test step against every cell at once, then the registered
// OR tree and then the decision step; a request walks this loop from one prime to the next.
// Once the cursor lies above the limit, a request is answered as exhausted from the test
// step; the first such request also steps over every number left between the last prime
// and the limit.
// Reset is synchronous and active low; it empties the row, sets the cursor to 2 and the
// limit to 65535. A stalled result holds the sequencer at its last step; no new request
// is taken until the current one has produced its result.
module prime_sieve_enumerator #(
    parameter int MAX_LIMIT = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] prime
    output logic [0:0]  m_tuser,   // [0] exhausted
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The limit register cannot exceed 16 bits, so larger settings behave as 65535.
    localparam int EFF_MAX = (MAX_LIMIT > pse_pkg::LIMIT_CEIL) ? pse_pkg::LIMIT_CEIL
                                                               : MAX_LIMIT;
    // One cell for every prime whose square can still lie under the limit.
    localparam int NCELLS  = pse_pkg::cells_for(EFF_MAX);

    pse_pkg::pse_state_t         state_reg, state_next;
    logic [pse_pkg::CAND_W-1:0]  cursor_reg, cursor_next;
    logic [pse_pkg::VALUE_W-1:0] limit_reg;
    logic [pse_pkg::VALUE_W-1:0] sq_reg;
    logic                        out_valid_reg;
    logic [pse_pkg::VALUE_W-1:0] prime_reg;
    logic                        exh_reg;

    pse_pkg::pse_cmd_t           cmd;
    logic [pse_pkg::VALUE_W-1:0] lim;
    logic                        composite;
    logic                        in_acc;
    logic                        cfg_wr;
    logic                        out_free;
    logic                        out_load;
    logic                        out_exh;
    logic                        past_lim;
    logic                        root_ok;

    // The limit in force is the register value saturated at the build-time maximum.
    assign lim = (limit_reg > pse_pkg::VALUE_W'(EFF_MAX)) ? pse_pkg::VALUE_W'(EFF_MAX)
                                                          : limit_reg;

    assign s_tready = (state_reg == pse_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign past_lim = cursor_reg > {1'b0, lim};
    // The current prime needs a cell only if its square does not exceed the limit.
    assign root_ok  = (cursor_reg[pse_pkg::CAND_W-1:pse_pkg::ROOT_W] == '0) && (sq_reg <= lim);

    // Configuration port: register 0 is the limit; writing it also starts the sieve afresh.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == pse_pkg::REG_LIMIT);
    assign prdata = (paddr[2] == pse_pkg::REG_LIMIT) ? {16'd0, limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= pse_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            limit_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= pse_pkg::ST_IDLE;
            cursor_reg <= pse_pkg::CURSOR_START;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
        end
    end

    // Square of the low byte, ready by the decision step of the same candidate.
    always_ff @(posedge aclk) begin
        sq_reg <= pse_pkg::VALUE_W'(cursor_reg[pse_pkg::ROOT_W-1:0])
                * pse_pkg::VALUE_W'(cursor_reg[pse_pkg::ROOT_W-1:0]);
    end

    always_comb begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        out_load        = 1'b0;
        out_exh         = 1'b0;
        cmd.clear       = 1'b0;
        cmd.test        = 1'b0;
        cmd.insert      = 1'b0;
        cmd.cand        = cursor_reg;
        cmd.fresh.valid = 1'b1;
        cmd.fresh.p     = cursor_reg[pse_pkg::ROOT_W-1:0];
        cmd.fresh.m     = {1'b0, sq_reg};
        unique case (state_reg)
            pse_pkg::ST_IDLE: begin
                if (in_acc) begin
                    state_next = pse_pkg::ST_TEST;
                    if (s_tdata[0]) begin
                        cmd.clear   = 1'b1;
                        cursor_next = pse_pkg::CURSOR_START;
                    end
                end
            end
            pse_pkg::ST_TEST: begin
                if (past_lim) begin
                    // Nothing left under the limit; the cursor stays where it is.
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_exh    = 1'b1;
                        state_next = pse_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.test   = 1'b1;
                    state_next = pse_pkg::ST_HIT;
                end
            end
            pse_pkg::ST_HIT: begin
                state_next = pse_pkg::ST_DECIDE;
            end
            pse_pkg::ST_DECIDE: begin
                if (composite) begin
                    cursor_next = cursor_reg + pse_pkg::CAND_W'(1);
                    state_next  = pse_pkg::ST_TEST;
                end else if (out_free) begin
                    out_load    = 1'b1;
                    cmd.insert  = root_ok;
                    cursor_next = cursor_reg + pse_pkg::CAND_W'(1);
                    state_next  = pse_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pse_pkg::ST_IDLE;
            end
        endcase
        if (cfg_wr) begin
            cmd.clear   = 1'b1;
            cursor_next = pse_pkg::CURSOR_START;
        end
    end

    pse_chain #(
        .NCELLS (NCELLS)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .composite (composite)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            prime_reg <= out_exh ? '0 : cursor_reg[pse_pkg::VALUE_W-1:0];
            exh_reg   <= out_exh;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = prime_reg;
    assign m_tuser[0] = exh_reg;

    // The cursor never falls below the first candidate.
    a_cursor_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg >= pse_pkg::CURSOR_START)
        else $error("cursor below two");

    // A composite candidate moves the cursor on by exactly one and tests again.
    a_composite_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pse_pkg::ST_DECIDE && composite && !cfg_wr) |=>
        (cursor_reg == $past(cursor_reg) + pse_pkg::CAND_W'(1))
        && (state_reg == pse_pkg::ST_TEST))
        else $error("composite candidate not stepped over");

    // A prime result is never below two.
    a_prime_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata >= 16'd2))
        else $error("prime result below two");

    // An accepted request always starts with a test step.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == pse_pkg::ST_TEST))
        else $error("request not started");

endmodule
